// ----- rtl/core/sed_pkg.sv -----
// Shared types, constants and character helpers for the string escape decoder.
package sed_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CHAR_BITS  = 8;
	localparam int CNT_OUT_BITS = 16;

	localparam logic [CHAR_BITS-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CHAR_BITS-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_BITS-1:0] CH_X      = 8'h78;
	localparam logic [CHAR_BITS-1:0] CH_N      = 8'h6E;
	localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_BODY = 3'd1,
		MODE_ESC  = 3'd2,
		MODE_HEX1 = 3'd3,
		MODE_HEX2 = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_HEX  = 2'd1,
		ERR_ESC  = 2'd2
	} err_t;

	typedef struct packed {
		mode_t                 mode;
		logic [3:0]            hex_hi;
		logic [COUNT_BITS-1:0] count;
	} ctx_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0]    data_byte;
		logic                    byte_valid;
		logic                    string_end;
		logic [CNT_OUT_BITS-1:0] byte_count;
		err_t                    error_code;
	} result_t;

	// {ok, nibble}
	function automatic logic [4:0] hex_value(input logic [CHAR_BITS-1:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// {ok, byte} for single-character escapes
	function automatic logic [CHAR_BITS:0] escape_value(input logic [CHAR_BITS-1:0] c);
		logic [CHAR_BITS:0] r;
		r = '0;
		unique case (c)
			8'h30:     r = {1'b1, CH_NUL};
			CH_N:      r = {1'b1, 8'h0A};
			8'h72:     r = {1'b1, 8'h0D};
			8'h74:     r = {1'b1, 8'h09};
			8'h62:     r = {1'b1, 8'h08};
			8'h61:     r = {1'b1, 8'h07};
			8'h66:     r = {1'b1, 8'h0C};
			8'h76:     r = {1'b1, 8'h0B};
			CH_BSLASH: r = {1'b1, CH_BSLASH};
			CH_QUOTE:  r = {1'b1, CH_QUOTE};
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/sed_step.sv -----
// Per-character decode: next context and result word from the current context.
module sed_step (
	input  sed_pkg::ctx_t               cur,
	input  logic [sed_pkg::CHAR_BITS-1:0] ch,
	output sed_pkg::ctx_t               nxt,
	output sed_pkg::result_t            res
);
	import sed_pkg::*;

	logic [4:0]           hx;
	logic [CHAR_BITS:0]   esc;

	assign hx  = hex_value(ch);
	assign esc = escape_value(ch);

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (cur.mode)
			MODE_BODY: begin
				if (ch == CH_QUOTE) begin
					res.string_end = 1'b1;
					nxt.mode = MODE_IDLE;
				end else if (ch == CH_BSLASH) begin
					nxt.mode = MODE_ESC;
				end else begin
					res.data_byte  = ch;
					res.byte_valid = 1'b1;
				end
			end
			MODE_ESC: begin
				if (ch == CH_X) begin
					nxt.mode = MODE_HEX1;
				end else if (!esc[CHAR_BITS]) begin
					res.error_code = ERR_ESC;
					nxt.mode = MODE_IDLE;
				end else begin
					res.data_byte  = esc[CHAR_BITS-1:0];
					res.byte_valid = 1'b1;
					nxt.mode = MODE_BODY;
				end
			end
			MODE_HEX1: begin
				if (!hx[4]) begin
					res.error_code = ERR_HEX;
					nxt.mode = MODE_IDLE;
				end else begin
					nxt.hex_hi = hx[3:0];
					nxt.mode = MODE_HEX2;
				end
			end
			MODE_HEX2: begin
				if (!hx[4]) begin
					res.error_code = ERR_HEX;
					nxt.mode = MODE_IDLE;
				end else begin
					res.data_byte  = {cur.hex_hi, hx[3:0]};
					res.byte_valid = 1'b1;
					nxt.mode = MODE_BODY;
				end
			end
			default: begin
				// opening character: dropped, new string starts
				nxt.count  = '0;
				nxt.hex_hi = '0;
				nxt.mode   = MODE_BODY;
			end
		endcase
		if (res.byte_valid && nxt.count != '1)
			nxt.count = nxt.count + 1'b1;
		res.byte_count = CNT_OUT_BITS'(nxt.count);
	end

endmodule

// ----- rtl/core/string_escape_decoder.sv -----
// Top level of the string escape decoder: input register, decode, result register.
//
// Input channel: in_valid/in_ready carry one source character (ch) per word,
// opening quote first. Output channel: out_valid/out_ready carry one result
// word per character: data_byte/byte_valid for a decoded byte, string_end on
// the closing quote with the final byte_count, error_code on a bad escape.
// After an error or a closing quote the next character is taken as a new
// opening character and dropped.
// Pipeline: an accepted word goes into the input register, then through the
// decode into the result register, which drives out_valid. Throughput: one
// word per cycle while the receiver does not stall, set by the combinational
// decode between the input register and the result register; the context
// (mode, hex nibble, count) is updated as a word moves to the result register.
// Reset clears both stages and returns the context to awaiting an opening
// character with a zero count. When the receiver stalls, the result register
// holds and one more word is taken into the input register; in_ready then
// drops until the result drains.
module string_escape_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sed_pkg::CHAR_BITS-1:0]   ch,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sed_pkg::CHAR_BITS-1:0]   data_byte,
	output logic                            byte_valid,
	output logic                            string_end,
	output logic [sed_pkg::CNT_OUT_BITS-1:0] byte_count,
	output logic [1:0]                      error_code
);
	import sed_pkg::*;

	logic                 valid_s1;
	logic [CHAR_BITS-1:0] ch_s1;
	logic                 valid_s2;
	result_t              res_s2;
	ctx_t                 ctx_q;
	ctx_t                 ctx_nxt;
	result_t              res_nxt;
	logic                 take_s2;
	logic                 adv_s1;

	assign take_s2  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && take_s2;
	assign in_ready = !valid_s1 || take_s2;

	sed_step u_step (
		.cur (ctx_q),
		.ch  (ch_s1),
		.nxt (ctx_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			ch_s1 <= ch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			ctx_q    <= '{mode: MODE_IDLE, hex_hi: '0, count: '0};
		end else begin
			if (take_s2)
				valid_s2 <= valid_s1;
			if (adv_s1)
				ctx_q <= ctx_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= res_nxt;
	end

	assign out_valid  = valid_s2;
	assign data_byte  = res_s2.data_byte;
	assign byte_valid = res_s2.byte_valid;
	assign string_end = res_s2.string_end;
	assign byte_count = res_s2.byte_count;
	assign error_code = res_s2.error_code;

	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(string_end && byte_valid))
		else $error("closing quote reported with a byte");

	a_err_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code != ERR_NONE) |-> !byte_valid && !string_end)
		else $error("error word carries a byte or end mark");

	a_err_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (res_nxt.error_code != ERR_NONE || res_nxt.string_end))
		|=> ctx_q.mode == MODE_IDLE)
		else $error("decoder did not return to await an opening character");

	a_no_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> data_byte == '0)
		else $error("data byte nonzero without byte_valid");

endmodule
